@@ rtl/core/twq_pkg.sv @@
// ----------------------------------------------------------------------------
// twq_pkg - shared definitions for the touch wake qualifier
// Field widths that the channel interfaces and the qualifier core both use,
// plus the register indexes and reset values that the qualifier core uses.
// ----------------------------------------------------------------------------
package twq_pkg;

  // Default raw coordinate width of the touch controller samples.
  localparam int COORD_BITS_DEF = 16;

  // Fixed field widths.
  localparam int PT_BITS      = 11;  // clamped coordinate on the result side
  localparam int THR_BITS     = 8;   // movement threshold register
  localparam int SIZE_BITS    = 12;  // screen width / height registers
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DAT_BITS = 12;

  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  typedef logic [CFG_DAT_BITS-1:0] cfg_dat_t;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_MOVE_THRESHOLD = 2'd0;
  localparam cfg_idx_t CFG_SCREEN_WIDTH   = 2'd1;
  localparam cfg_idx_t CFG_SCREEN_HEIGHT  = 2'd2;

  // Register reset values.
  localparam logic [THR_BITS-1:0]  MOVE_THRESHOLD_RST = 8'd8;
  localparam logic [SIZE_BITS-1:0] SCREEN_WIDTH_RST   = 12'd480;
  localparam logic [SIZE_BITS-1:0] SCREEN_HEIGHT_RST  = 12'd800;

  // Largest screen size that still maps to size - 1 as the clamp limit.
  localparam logic [SIZE_BITS-1:0] SIZE_SAT = 12'd2048;

endpackage

@@ rtl/core/twq_channels.sv @@
// ----------------------------------------------------------------------------
// twq_channels - request channels of the touch wake qualifier
// Sample, result and configuration write channels, each with valid/ready.
// ----------------------------------------------------------------------------
interface twq_in_if #(
  parameter int COORD_BITS = twq_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic                         touch_down;
  logic signed [COORD_BITS-1:0] raw_x;
  logic signed [COORD_BITS-1:0] raw_y;
  logic                         display_lit;

  modport source (output valid, touch_down, raw_x, raw_y, display_lit, input ready);
  modport sink   (input valid, touch_down, raw_x, raw_y, display_lit, output ready);
endinterface

interface twq_out_if;
  logic                           valid;
  logic                           ready;
  logic                           report_pressed;
  logic [twq_pkg::PT_BITS-1:0]    point_x;
  logic [twq_pkg::PT_BITS-1:0]    point_y;
  logic                           activity;

  modport source (output valid, report_pressed, point_x, point_y, activity, input ready);
  modport sink   (input valid, report_pressed, point_x, point_y, activity, output ready);
endinterface

interface twq_cfg_if;
  logic              valid;
  logic              ready;
  twq_pkg::cfg_idx_t index;
  twq_pkg::cfg_dat_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/core/touch_wake_qualifier.sv @@
// ----------------------------------------------------------------------------
// touch_wake_qualifier - qualifies raw touch samples against display power
// Decides per poll whether a touch is forwarded as a press, swallowed as a
// wake tap, or only refreshes the idle timer, and clamps the coordinates.
// ----------------------------------------------------------------------------
//
//  Channel  | Dir | Payload                                       | Handshake
//  ---------+-----+-----------------------------------------------+-------------
//  in_if    | in  | touch_down, raw_x, raw_y, display_lit         | valid/ready
//  out_if   | out | report_pressed, point_x, point_y, activity    | valid/ready
//  cfg_if   | in  | index, data (move threshold, screen w/h)      | valid/ready
//
// One sample is accepted per cycle while in_if.ready is high, and each
// sample yields exactly one result. A sample is caught in the input register,
// qualified by a single pass of logic against the held touch state, and the
// result lands in the output register.
// Throughput is set by the output register alone; a stalled result holds the
// input register, and in_if.ready drops only when both stages are full.
// rst_n is synchronous and active low; it empties both stages, restores the
// configuration registers and sets the touch state to "screen lit, no touch".
// Configuration writes are always taken and are expected while idle.
// ----------------------------------------------------------------------------
module touch_wake_qualifier #(
  parameter int COORD_BITS = twq_pkg::COORD_BITS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  twq_in_if.sink    in_if,
  twq_out_if.source out_if,
  twq_cfg_if.sink   cfg_if
);
  import twq_pkg::*;

  // Width used to compare a signed coordinate against an unsigned limit.
  localparam int CMPW = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 1;
  // Width of a coordinate difference, one bit wider than the coordinate.
  localparam int DIFW = COORD_BITS + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // Configuration registers.
  logic [THR_BITS-1:0]  move_threshold_r;
  logic [SIZE_BITS-1:0] screen_width_r;
  logic [SIZE_BITS-1:0] screen_height_r;

  // Input stage.
  logic   s1_valid_r;
  logic   s1_down_r;
  coord_t s1_x_r;
  coord_t s1_y_r;
  logic   s1_lit_r;

  // Touch state carried from poll to poll.
  logic   was_down_r,            was_down_nxt;
  logic   swallow_active_r,      swallow_active_nxt;
  logic   wake_release_needed_r, wake_release_needed_nxt;
  logic   prev_lit_r;
  coord_t last_x_r,              last_x_nxt;
  coord_t last_y_r,              last_y_nxt;

  // Result stage.
  logic               out_valid_r;
  logic               pressed_r,  pressed_nxt;
  logic [PT_BITS-1:0] pt_x_r,     pt_x_nxt;
  logic [PT_BITS-1:0] pt_y_r,     pt_y_nxt;
  logic               act_r,      act_nxt;

  logic advance;
  logic in_take;
  logic moved;
  logic wake_block;

  // The input stage moves on whenever the result register is free or is
  // being drained in this cycle.
  assign advance = !out_valid_r || out_if.ready;
  assign in_if.ready = !s1_valid_r || advance;
  assign in_take = in_if.valid && in_if.ready;

  assign cfg_if.ready = 1'b1;

  assign out_if.valid          = out_valid_r;
  assign out_if.report_pressed = pressed_r;
  assign out_if.point_x        = pt_x_r;
  assign out_if.point_y        = pt_y_r;
  assign out_if.activity       = act_r;

  // Absolute difference of two coordinates, one bit wider so it never wraps.
  function automatic logic [DIFW-1:0] abs_diff(input coord_t a, input coord_t b);
    logic signed [DIFW-1:0] d;
    d = DIFW'(signed'(a)) - DIFW'(signed'(b));
    return d[DIFW-1] ? DIFW'(-d) : DIFW'(d);
  endfunction

  // Clamp a signed coordinate to [0, size-1], with the limit saturating at
  // the largest result value and an empty screen giving zero.
  function automatic logic [PT_BITS-1:0] clamp_coord(input coord_t v,
                                                     input logic [SIZE_BITS-1:0] size);
    logic [PT_BITS-1:0]     lim;
    logic signed [CMPW-1:0] v_ext;
    logic signed [CMPW-1:0] lim_ext;
    if (size == '0) begin
      lim = '0;
    end else if (size > SIZE_SAT) begin
      lim = '1;
    end else begin
      lim = PT_BITS'(size - 1'b1);
    end
    v_ext   = CMPW'(signed'(v));
    lim_ext = signed'(CMPW'(lim));
    if (v_ext < 0) begin
      return '0;
    end else if (v_ext > lim_ext) begin
      return lim;
    end
    return v_ext[PT_BITS-1:0];
  endfunction

  assign moved = (abs_diff(s1_x_r, last_x_r) >= DIFW'(move_threshold_r)) ||
                 (abs_diff(s1_y_r, last_y_r) >= DIFW'(move_threshold_r));

  // A fall of the screen from lit to dark blocks a finger already down from
  // waking it again.
  assign wake_block = wake_release_needed_r || (!s1_lit_r && prev_lit_r);

  always_comb begin
    was_down_nxt            = was_down_r;
    swallow_active_nxt      = swallow_active_r;
    wake_release_needed_nxt = wake_block;
    last_x_nxt              = last_x_r;
    last_y_nxt              = last_y_r;
    pressed_nxt             = 1'b0;
    pt_x_nxt                = '0;
    pt_y_nxt                = '0;
    act_nxt                 = 1'b0;

    if (!s1_lit_r) begin
      // Screen dark: a release clears all touch flags, a fresh tap only wakes.
      if (!s1_down_r) begin
        was_down_nxt            = 1'b0;
        wake_release_needed_nxt = 1'b0;
        swallow_active_nxt      = 1'b0;
      end else if (!wake_block) begin
        act_nxt                 = 1'b1;
        swallow_active_nxt      = 1'b1;
        wake_release_needed_nxt = 1'b1;
        was_down_nxt            = 1'b1;
        last_x_nxt              = s1_x_r;
        last_y_nxt              = s1_y_r;
      end
    end else if (swallow_active_r) begin
      // The wake tap is eaten until the finger lifts.
      if (!s1_down_r) begin
        swallow_active_nxt = 1'b0;
        was_down_nxt       = 1'b0;
      end
    end else if (s1_down_r) begin
      act_nxt      = !was_down_r || moved;
      was_down_nxt = 1'b1;
      last_x_nxt   = s1_x_r;
      last_y_nxt   = s1_y_r;
      pressed_nxt  = 1'b1;
      pt_x_nxt     = clamp_coord(s1_x_r, screen_width_r);
      pt_y_nxt     = clamp_coord(s1_y_r, screen_height_r);
    end else begin
      was_down_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      move_threshold_r <= MOVE_THRESHOLD_RST;
      screen_width_r   <= SCREEN_WIDTH_RST;
      screen_height_r  <= SCREEN_HEIGHT_RST;
    end else if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        CFG_MOVE_THRESHOLD: move_threshold_r <= cfg_if.data[THR_BITS-1:0];
        CFG_SCREEN_WIDTH:   screen_width_r   <= cfg_if.data[SIZE_BITS-1:0];
        CFG_SCREEN_HEIGHT:  screen_height_r  <= cfg_if.data[SIZE_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      s1_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_down_r <= in_if.touch_down;
      s1_x_r    <= in_if.raw_x;
      s1_y_r    <= in_if.raw_y;
      s1_lit_r  <= in_if.display_lit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_down_r            <= 1'b0;
      swallow_active_r      <= 1'b0;
      wake_release_needed_r <= 1'b0;
      prev_lit_r            <= 1'b1;
      last_x_r              <= '0;
      last_y_r              <= '0;
      out_valid_r           <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        was_down_r            <= was_down_nxt;
        swallow_active_r      <= swallow_active_nxt;
        wake_release_needed_r <= wake_release_needed_nxt;
        prev_lit_r            <= s1_lit_r;
        last_x_r              <= last_x_nxt;
        last_y_r              <= last_y_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      pressed_r <= pressed_nxt;
      pt_x_r    <= pt_x_nxt;
      pt_y_r    <= pt_y_nxt;
      act_r     <= act_nxt;
    end
  end

  // A swallowed touch always comes from a wake tap, so the finger is marked
  // down and a release is still owed.
  a_swallow_implies_flags: assert property (@(posedge clk) disable iff (!rst_n)
    swallow_active_r |-> (was_down_r && wake_release_needed_r))
    else $error("swallow set without touch-down and wake-release flags");

  // A released result carries zero coordinates.
  a_release_zero_point: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !pressed_r) |-> (pt_x_r == '0 && pt_y_r == '0))
    else $error("released result with non-zero coordinates");

  // A swallowed or dark poll is never forwarded as a press.
  a_no_press_when_held: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_valid_r && (!s1_lit_r || swallow_active_r)) |=> !pressed_r)
    else $error("press forwarded while dark or swallowing");

  // The input stage is never overwritten while it is stalled.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !advance) |-> !in_if.ready)
    else $error("input stage accepts a request while stalled");

endmodule
